// File: hdl/aabb_pairwise_collision_unit_defines.svh
// Assertion macros shared by the collision unit RTL.
`ifndef AABB_PAIRWISE_COLLISION_UNIT_DEFINES_SVH
`define AABB_PAIRWISE_COLLISION_UNIT_DEFINES_SVH

`ifndef SYNTH
`define AAPC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("aapc assertion failed");
`define AAPC_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("aapc assertion failed");
`else
`define AAPC_ASSERT(lbl, clk, rst, prop)
`define AAPC_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// File: hdl/aapc_pkg.sv
`default_nettype none

package aapc_pkg;

   localparam int SLOTS_DEF = 8;
   localparam int KINDS_DEF = 16;
   localparam int MAX_PAIRS = 28;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_SWEEP  = 2'd2;
   localparam logic [1:0] CMD_MASK   = 2'd3;

   localparam logic [2:0] ST_ADDED   = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_REMOVED = 3'd2;
   localparam logic [2:0] ST_MASKSET = 3'd3;
   localparam logic [2:0] ST_PAIR    = 3'd4;
   localparam logic [2:0] ST_DONE    = 3'd5;

   // one slot table entry
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [14:0]        w;
      logic [14:0]        h;
      logic [3:0]         kind;
      logic               notify;
   } entry_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] status;
      logic [2:0] slot_a;
      logic [2:0] slot_b;
      logic       notify_a;
      logic       notify_b;
      logic       last;
   } rsp_type;

   // right or bottom edge, never wraps in 17 bits
   function automatic logic signed [16:0] far_edge(input logic signed [15:0] pos,
                                                   input logic [14:0] len);
      far_edge = $signed({pos[15], pos}) + $signed({2'b00, len});
   endfunction

endpackage

`default_nettype wire

// File: hdl/aapc_ram.sv
`default_nettype none

module aapc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/aapc_sweep.sv
`default_nettype none

`include "aabb_pairwise_collision_unit_defines.svh"

module aapc_sweep import aapc_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF,
   parameter int KINDS = KINDS_DEF,
   localparam int SW = $clog2(SLOTS),
   localparam int KW = $clog2(KINDS)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             adv,
   input  wire logic [SLOTS-1:0] slot_vld,
   input  wire logic [KINDS-1:0] mask_vld,
   output logic      [SW-1:0]    slot_rd_addr,
   input  wire entry_type        slot_rd_data,
   output logic      [KW-1:0]    mask_rd_addr,
   input  wire logic [KINDS-1:0] mask_rd_data,
   output rsp_type               result,
   output logic                  busy
);

   localparam int PW = $clog2(MAX_PAIRS + 1);
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
   localparam logic [SW-1:0] LAST_ROW  = SW'(SLOTS - 2);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_A0    = 3'd1;
   localparam logic [2:0] PH_A1    = 3'd2;
   localparam logic [2:0] PH_A2    = 3'd3;
   localparam logic [2:0] PH_K     = 3'd4;
   localparam logic [2:0] PH_DRAIN = 3'd5;

   logic [2:0]         phase_ff, phase_in;
   logic [SW-1:0]      i_ff, i_in, k_ff, k_in;
   logic [PW-1:0]      pairs_ff, pairs_in;

   // row-slot box, kind, notify and its mask row
   logic signed [16:0] a_x_ff, a_x_in, a_y_ff, a_y_in;
   logic signed [16:0] a_xr_ff, a_xr_in, a_yb_ff, a_yb_in;
   logic [3:0]         a_kind_ff, a_kind_in;
   logic               a_notify_ff, a_notify_in;
   logic [KINDS-1:0]   row_a_ff, row_a_in;
   logic               row_a_ok_ff, row_a_ok_in;
   logic               mask_ok_ff, mask_ok_in;

   // stage 0: slot read issued; stage 1: overlap done, mask row of b read
   logic               p0_vld_ff, p0_vld_in;
   logic [SW-1:0]      p0_i_ff, p0_i_in, p0_k_ff, p0_k_in;
   logic               p1_vld_ff, p1_vld_in;
   logic [SW-1:0]      p1_i_ff, p1_i_in, p1_k_ff, p1_k_in;
   logic               p1_na_ff, p1_na_in;
   logic               p1_nb_en_ff, p1_nb_en_in;
   logic [KW-1:0]      p1_kind_a_ff, p1_kind_a_in;
   logic               p1_kind_a_ok_ff, p1_kind_a_ok_in;

   logic signed [16:0] b_x, b_y, b_xr, b_yb;
   logic               apart, kind_b_ok, na, nb, pair_hit;

   assign slot_rd_addr = (phase_ff == PH_K) ? k_ff : i_ff;
   assign mask_rd_addr = slot_rd_data.kind[KW-1:0];
   assign busy         = (phase_ff != PH_IDLE);

   always_comb begin
      b_x  = {slot_rd_data.x[15], slot_rd_data.x};
      b_y  = {slot_rd_data.y[15], slot_rd_data.y};
      b_xr = far_edge(slot_rd_data.x, slot_rd_data.w);
      b_yb = far_edge(slot_rd_data.y, slot_rd_data.h);
      apart = (b_xr < a_x_ff) || (b_yb < a_y_ff) || (b_x > a_xr_ff) || (b_y > a_yb_ff);
      kind_b_ok = (32'(slot_rd_data.kind) < KINDS);
      na = row_a_ok_ff && kind_b_ok && row_a_ff[slot_rd_data.kind[KW-1:0]] && a_notify_ff;
      nb = p1_nb_en_ff && p1_kind_a_ok_ff && mask_ok_ff && mask_rd_data[p1_kind_a_ff];
      pair_hit = p1_vld_ff && (p1_na_ff || nb) && (pairs_ff != PW'(MAX_PAIRS));

      result = '0;
      if (pair_hit) begin
         result.valid    = 1'b1;
         result.status   = ST_PAIR;
         result.slot_a   = 3'(p1_i_ff);
         result.slot_b   = 3'(p1_k_ff);
         result.notify_a = p1_na_ff;
         result.notify_b = nb;
      end else if (phase_ff == PH_DRAIN && !p0_vld_ff && !p1_vld_ff) begin
         result.valid  = 1'b1;
         result.status = ST_DONE;
         result.last   = 1'b1;
      end

      phase_in        = phase_ff;
      i_in            = i_ff;
      k_in            = k_ff;
      pairs_in        = pairs_ff;
      a_x_in          = a_x_ff;
      a_y_in          = a_y_ff;
      a_xr_in         = a_xr_ff;
      a_yb_in         = a_yb_ff;
      a_kind_in       = a_kind_ff;
      a_notify_in     = a_notify_ff;
      row_a_in        = row_a_ff;
      row_a_ok_in     = row_a_ok_ff;
      mask_ok_in      = mask_ok_ff;
      p0_vld_in       = p0_vld_ff;
      p0_i_in         = p0_i_ff;
      p0_k_in         = p0_k_ff;
      p1_vld_in       = p1_vld_ff;
      p1_i_in         = p1_i_ff;
      p1_k_in         = p1_k_ff;
      p1_na_in        = p1_na_ff;
      p1_nb_en_in     = p1_nb_en_ff;
      p1_kind_a_in    = p1_kind_a_ff;
      p1_kind_a_ok_in = p1_kind_a_ok_ff;

      if (adv) begin
         // mask row valid flag travels with the mask read
         mask_ok_in = kind_b_ok && mask_vld[slot_rd_data.kind[KW-1:0]];

         p1_vld_in       = p0_vld_ff && !apart;
         p1_i_in         = p0_i_ff;
         p1_k_in         = p0_k_ff;
         p1_na_in        = na;
         p1_nb_en_in     = slot_rd_data.notify;
         p1_kind_a_in    = a_kind_ff[KW-1:0];
         p1_kind_a_ok_in = (32'(a_kind_ff) < KINDS);

         p0_vld_in = (phase_ff == PH_K) && slot_vld[k_ff];
         p0_i_in   = i_ff;
         p0_k_in   = k_ff;

         if (pair_hit) begin
            pairs_in = pairs_ff + PW'(1);
         end

         case (phase_ff)
            PH_IDLE: begin
               if (start) begin
                  i_in     = '0;
                  pairs_in = '0;
                  phase_in = PH_A0;
               end
            end
            PH_A0: begin
               if (slot_vld[i_ff]) begin
                  phase_in = PH_A1;
               end else if (i_ff == LAST_ROW) begin
                  phase_in = PH_DRAIN;
               end else begin
                  i_in = i_ff + SW'(1);
               end
            end
            PH_A1: begin
               a_x_in      = b_x;
               a_y_in      = b_y;
               a_xr_in     = b_xr;
               a_yb_in     = b_yb;
               a_kind_in   = slot_rd_data.kind;
               a_notify_in = slot_rd_data.notify;
               phase_in    = PH_A2;
            end
            PH_A2: begin
               row_a_in    = mask_rd_data;
               row_a_ok_in = mask_ok_ff;
               k_in        = i_ff + SW'(1);
               phase_in    = PH_K;
            end
            PH_K: begin
               if (k_ff == LAST_SLOT) begin
                  if (i_ff == LAST_ROW) begin
                     phase_in = PH_DRAIN;
                  end else begin
                     i_in     = i_ff + SW'(1);
                     phase_in = PH_A0;
                  end
               end else begin
                  k_in = k_ff + SW'(1);
               end
            end
            PH_DRAIN: begin
               if (!p0_vld_ff && !p1_vld_ff) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pairs_ff  <= '0;
         p0_vld_ff <= 1'b0;
         p1_vld_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         pairs_ff  <= pairs_in;
         p0_vld_ff <= p0_vld_in;
         p1_vld_ff <= p1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff            <= i_in;
      k_ff            <= k_in;
      a_x_ff          <= a_x_in;
      a_y_ff          <= a_y_in;
      a_xr_ff         <= a_xr_in;
      a_yb_ff         <= a_yb_in;
      a_kind_ff       <= a_kind_in;
      a_notify_ff     <= a_notify_in;
      row_a_ff        <= row_a_in;
      row_a_ok_ff     <= row_a_ok_in;
      mask_ok_ff      <= mask_ok_in;
      p0_i_ff         <= p0_i_in;
      p0_k_ff         <= p0_k_in;
      p1_i_ff         <= p1_i_in;
      p1_k_ff         <= p1_k_in;
      p1_na_ff        <= p1_na_in;
      p1_nb_en_ff     <= p1_nb_en_in;
      p1_kind_a_ff    <= p1_kind_a_in;
      p1_kind_a_ok_ff <= p1_kind_a_ok_in;
   end

   `AAPC_ASSERT(a_pairs_cap, clock, reset, pairs_ff <= PW'(MAX_PAIRS))
   `AAPC_ASSERT(a_pair_order, clock, reset, p1_vld_ff |-> p1_i_ff < p1_k_ff)
   `AAPC_ASSERT(a_mask_port, clock, reset, p0_vld_ff |-> phase_ff != PH_A1)
   `AAPC_ASSERT(a_idle_empty, clock, reset, phase_ff == PH_IDLE |-> !p0_vld_ff && !p1_vld_ff)

endmodule

`default_nettype wire

// File: hdl/aabb_pairwise_collision_unit.sv
// Box collision table with a pairwise sweep.
// Request channel (req_*): one item per command. Add puts a box into the
// lowest free slot, remove frees a slot, set-mask loads one row of the
// kind reaction mask, sweep tests every valid slot pair for overlap.
// Response channel (rsp_*): add, remove and set-mask give one item in the
// cycle after acceptance. A sweep gives up to 28 pair items and then a done
// item; rsp_last marks the final item of each command.
// A sweep tests one slot pair per cycle while no response is held stalled,
// through the slot table memory read port, plus a row setup (phases A0, A1,
// A2) per valid lower slot to fetch its entry and its mask row.
// Only one command is in flight; req_stall is high during a sweep.
// Reset clears all slot valid bits and the mask row valid bits (rows read as zero until
// written). When rsp_stall is high the whole sweep freezes with the held
// item; a new request is still taken while a finished item waits, as long
// as the receiver does not stall.
`default_nettype none

`include "aabb_pairwise_collision_unit_defines.svh"

module aabb_pairwise_collision_unit import aapc_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF,
   parameter int KINDS = KINDS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_command,
   input  wire logic [2:0]         req_slot,
   input  wire logic signed [15:0] req_rect_x,
   input  wire logic signed [15:0] req_rect_y,
   input  wire logic [14:0]        req_rect_w,
   input  wire logic [14:0]        req_rect_h,
   input  wire logic [3:0]         req_kind,
   input  wire logic               req_notify_enable,
   input  wire logic [15:0]        req_mask_bits,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_status,
   output logic [2:0]              rsp_slot_a,
   output logic [2:0]              rsp_slot_b,
   output logic                    rsp_notify_a,
   output logic                    rsp_notify_b,
   output logic                    rsp_last
);

   localparam int SW = $clog2(SLOTS);
   localparam int KW = $clog2(KINDS);

   logic [SLOTS-1:0] slot_vld_ff, slot_vld_in;
   logic [KINDS-1:0] mask_vld_ff, mask_vld_in;
   rsp_type          rsp_ff, rsp_in;

   logic             adv, req_accept, sweep_start, sweep_busy;
   logic             free_any, slot_wr, mask_wr;
   logic [SW-1:0]    free_idx;
   entry_type        wr_entry, slot_rd_data;
   logic [SW-1:0]    slot_rd_addr;
   logic [KW-1:0]    mask_rd_addr;
   logic [KINDS-1:0] mask_rd_data;
   rsp_type          sweep_result;

   assign adv         = !rsp_ff.valid || !rsp_stall;
   assign req_stall   = sweep_busy || !adv;
   assign req_accept  = req_valid && !req_stall;
   assign sweep_start = req_accept && (req_command == CMD_SWEEP);
   assign slot_wr     = req_accept && (req_command == CMD_ADD) && free_any;
   assign mask_wr     = req_accept && (req_command == CMD_MASK) && (32'(req_kind) < KINDS);

   always_comb begin
      wr_entry.x      = req_rect_x;
      wr_entry.y      = req_rect_y;
      wr_entry.w      = req_rect_w;
      wr_entry.h      = req_rect_h;
      wr_entry.kind   = req_kind;
      wr_entry.notify = req_notify_enable;
   end

   // lowest free slot
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int j = SLOTS - 1; j >= 0; j--) begin
         if (!slot_vld_ff[j]) begin
            free_any = 1'b1;
            free_idx = SW'(j);
         end
      end
   end

   always_comb begin
      slot_vld_in = slot_vld_ff;
      mask_vld_in = mask_vld_ff;
      rsp_in      = rsp_ff;
      if (slot_wr) begin
         slot_vld_in[free_idx] = 1'b1;
      end
      if (mask_wr) begin
         mask_vld_in[req_kind[KW-1:0]] = 1'b1;
      end
      if (adv) begin
         rsp_in = sweep_result;
         if (req_accept) begin
            rsp_in      = '0;
            rsp_in.last = 1'b1;
            case (req_command)
               CMD_ADD: begin
                  rsp_in.valid = 1'b1;
                  if (free_any) begin
                     rsp_in.status = ST_ADDED;
                     rsp_in.slot_a = 3'(free_idx);
                  end else begin
                     rsp_in.status = ST_FULL;
                  end
               end
               CMD_REMOVE: begin
                  rsp_in.valid  = 1'b1;
                  rsp_in.status = ST_REMOVED;
                  rsp_in.slot_a = req_slot;
                  if (32'(req_slot) < SLOTS) begin
                     slot_vld_in[SW'(req_slot)] = 1'b0;
                  end
               end
               CMD_MASK: begin
                  rsp_in.valid  = 1'b1;
                  rsp_in.status = ST_MASKSET;
               end
               CMD_SWEEP: begin
                  rsp_in.valid = 1'b0;
               end
               default: begin
                  rsp_in.valid = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
         mask_vld_ff <= '0;
         rsp_ff      <= '0;
      end else begin
         slot_vld_ff <= slot_vld_in;
         mask_vld_ff <= mask_vld_in;
         rsp_ff      <= rsp_in;
      end
   end

   aapc_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr),
      .wr_addr (free_idx),
      .wr_data (wr_entry),
      .rd_en   (adv),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   aapc_ram #(
      .WIDTH(KINDS),
      .DEPTH(KINDS)
   ) u_mask_ram (
      .clock   (clock),
      .wr_en   (mask_wr),
      .wr_addr (req_kind[KW-1:0]),
      .wr_data (req_mask_bits[KINDS-1:0]),
      .rd_en   (adv),
      .rd_addr (mask_rd_addr),
      .rd_data (mask_rd_data)
   );

   aapc_sweep #(
      .SLOTS(SLOTS),
      .KINDS(KINDS)
   ) u_sweep (
      .clock        (clock),
      .reset        (reset),
      .start        (sweep_start),
      .adv          (adv),
      .slot_vld     (slot_vld_ff),
      .mask_vld     (mask_vld_ff),
      .slot_rd_addr (slot_rd_addr),
      .slot_rd_data (slot_rd_data),
      .mask_rd_addr (mask_rd_addr),
      .mask_rd_data (mask_rd_data),
      .result       (sweep_result),
      .busy         (sweep_busy)
   );

   assign rsp_valid    = rsp_ff.valid;
   assign rsp_status   = rsp_ff.status;
   assign rsp_slot_a   = rsp_ff.slot_a;
   assign rsp_slot_b   = rsp_ff.slot_b;
   assign rsp_notify_a = rsp_ff.notify_a;
   assign rsp_notify_b = rsp_ff.notify_b;
   assign rsp_last     = rsp_ff.last;

   `AAPC_ASSERT(a_add_fills, clock, reset, slot_wr |=> $countones(slot_vld_ff) == $past($countones(slot_vld_ff)) + 1)
   `AAPC_ASSERT(a_sweep_busy, clock, reset, sweep_start |=> sweep_busy)
   `AAPC_ASSERT(a_one_source, clock, reset, sweep_busy |-> !slot_wr && !mask_wr)

endmodule

`default_nettype wire

// File: tb/sv/tb_aabb_pairwise_collision_unit.sv
`default_nettype none

module tb_aabb_pairwise_collision_unit;
   import aapc_pkg::*;

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] slot_a;
      logic [2:0] slot_b;
      logic       notify_a;
      logic       notify_b;
      logic       is_last;
   } result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_command = CMD_ADD;
   logic [2:0]         req_slot = '0;
   logic signed [15:0] req_rect_x = '0;
   logic signed [15:0] req_rect_y = '0;
   logic [14:0]        req_rect_w = '0;
   logic [14:0]        req_rect_h = '0;
   logic [3:0]         req_kind = '0;
   logic               req_notify_enable = 1'b0;
   logic [15:0]        req_mask_bits = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_status;
   logic [2:0]         rsp_slot_a;
   logic [2:0]         rsp_slot_b;
   logic               rsp_notify_a;
   logic               rsp_notify_b;
   logic               rsp_last;

   // shadow copy of the collision table
   bit                 tbl_valid [SLOTS_DEF];
   logic signed [15:0] tbl_x [SLOTS_DEF];
   logic signed [15:0] tbl_y [SLOTS_DEF];
   logic [14:0]        tbl_w [SLOTS_DEF];
   logic [14:0]        tbl_h [SLOTS_DEF];
   logic [3:0]         tbl_kind [SLOTS_DEF];
   logic               tbl_notify [SLOTS_DEF];
   bit [15:0]          react_mask [KINDS_DEF];

   result_t pending_results[$];
   int      fail_count = 0;
   int      send_idle_pct = 0;
   int      rsp_idle_pct = 0;

   aabb_pairwise_collision_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_slot          (req_slot),
      .req_rect_x        (req_rect_x),
      .req_rect_y        (req_rect_y),
      .req_rect_w        (req_rect_w),
      .req_rect_h        (req_rect_h),
      .req_kind          (req_kind),
      .req_notify_enable (req_notify_enable),
      .req_mask_bits     (req_mask_bits),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_slot_a        (rsp_slot_a),
      .rsp_slot_b        (rsp_slot_b),
      .rsp_notify_a      (rsp_notify_a),
      .rsp_notify_b      (rsp_notify_b),
      .rsp_last          (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic result_t make_result(logic [2:0] st, int a, int b, bit na, bit nb,
                                           bit lst);
      result_t r;
      r.status   = st;
      r.slot_a   = 3'(a);
      r.slot_b   = 3'(b);
      r.notify_a = na;
      r.notify_b = nb;
      r.is_last  = lst;
      return r;
   endfunction

   function automatic bit kind_reacts(logic [3:0] row, logic [3:0] col);
      if (row >= KINDS_DEF || col >= KINDS_DEF) return 1'b0;
      return react_mask[row][col];
   endfunction

   // inclusive test: touching edges count as overlap
   function automatic bit boxes_overlap(int a, int b);
      int ax = tbl_x[a];
      int ay = tbl_y[a];
      int aw = tbl_w[a];
      int ah = tbl_h[a];
      int bx = tbl_x[b];
      int by = tbl_y[b];
      int bw = tbl_w[b];
      int bh = tbl_h[b];
      return !(bx + bw < ax || by + bh < ay || bx > ax + aw || by > ay + ah);
   endfunction

   task automatic predict_command_results(logic [1:0] cmd, logic [2:0] slot,
                                          logic signed [15:0] x, logic signed [15:0] y,
                                          logic [14:0] w, logic [14:0] h, logic [3:0] kind,
                                          logic notify, logic [15:0] mask);
      int  free_slot;
      int  pairs;
      bit  na;
      bit  nb;
      free_slot = -1;
      pairs = 0;
      case (cmd)
         CMD_ADD: begin
            for (int i = SLOTS_DEF - 1; i >= 0; i--)
               if (!tbl_valid[i]) free_slot = i;
            if (free_slot < 0) begin
               pending_results.push_back(make_result(ST_FULL, 0, 0, 0, 0, 1));
            end else begin
               tbl_valid[free_slot]  = 1'b1;
               tbl_x[free_slot]      = x;
               tbl_y[free_slot]      = y;
               tbl_w[free_slot]      = w;
               tbl_h[free_slot]      = h;
               tbl_kind[free_slot]   = kind;
               tbl_notify[free_slot] = notify;
               pending_results.push_back(make_result(ST_ADDED, free_slot, 0, 0, 0, 1));
            end
         end
         CMD_REMOVE: begin
            if (slot < SLOTS_DEF) tbl_valid[slot] = 1'b0;
            pending_results.push_back(make_result(ST_REMOVED, slot, 0, 0, 0, 1));
         end
         CMD_MASK: begin
            if (kind < KINDS_DEF) react_mask[kind] = mask & 16'((1 << KINDS_DEF) - 1);
            pending_results.push_back(make_result(ST_MASKSET, 0, 0, 0, 0, 1));
         end
         default: begin
            for (int i = 0; i < SLOTS_DEF; i++) begin
               if (!tbl_valid[i]) continue;
               for (int k = i + 1; k < SLOTS_DEF; k++) begin
                  if (!tbl_valid[k] || !boxes_overlap(i, k)) continue;
                  na = kind_reacts(tbl_kind[i], tbl_kind[k]) && tbl_notify[i];
                  nb = kind_reacts(tbl_kind[k], tbl_kind[i]) && tbl_notify[k];
                  if ((na || nb) && pairs < MAX_PAIRS) begin
                     pending_results.push_back(make_result(ST_PAIR, i, k, na, nb, 0));
                     pairs++;
                  end
               end
            end
            pending_results.push_back(make_result(ST_DONE, 0, 0, 0, 0, 1));
         end
      endcase
   endtask

   // valid stays high across back-to-back items; only lowered in a gap
   task automatic send_command(logic [1:0] cmd, logic [2:0] slot, logic signed [15:0] x,
                               logic signed [15:0] y, logic [14:0] w, logic [14:0] h,
                               logic [3:0] kind, logic notify, logic [15:0] mask);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_slot          <= slot;
      req_rect_x        <= x;
      req_rect_y        <= y;
      req_rect_w        <= w;
      req_rect_h        <= h;
      req_kind          <= kind;
      req_notify_enable <= notify;
      req_mask_bits     <= mask;
      do @(posedge clock); while (req_stall);
      predict_command_results(cmd, slot, x, y, w, h, kind, notify, mask);
   endtask

   task automatic send_add(logic signed [15:0] x, logic signed [15:0] y, logic [14:0] w,
                           logic [14:0] h, logic [3:0] kind, logic notify);
      send_command(CMD_ADD, '0, x, y, w, h, kind, notify, '0);
   endtask

   task automatic send_remove(logic [2:0] slot);
      send_command(CMD_REMOVE, slot, '0, '0, '0, '0, '0, 1'b0, '0);
   endtask

   task automatic send_sweep();
      send_command(CMD_SWEEP, '0, '0, '0, '0, '0, '0, 1'b0, '0);
   endtask

   task automatic send_mask(logic [3:0] row, logic [15:0] bits);
      send_command(CMD_MASK, '0, '0, '0, '0, '0, row, 1'b0, bits);
   endtask

   task automatic check_result();
      result_t got;
      result_t want;
      got = make_result(rsp_status, rsp_slot_a, rsp_slot_b, rsp_notify_a, rsp_notify_b,
                        rsp_last);
      if (pending_results.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("ERROR %0t: unexpected result status=%0d a=%0d b=%0d", $time,
                     got.status, got.slot_a, got.slot_b);
         return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
         fail_count++;
         // fields: status/a/b/na/nb/last
         if (fail_count <= 10)
            $display("ERROR %0t: exp %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
                     $time,
                     want.status, want.slot_a, want.slot_b, want.notify_a, want.notify_b,
                     want.is_last, got.status, got.slot_a, got.slot_b, got.notify_a,
                     got.notify_b, got.is_last);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_result();
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   task automatic test_empty_sweep();
      send_sweep();
   endtask

   // eight mutually overlapping boxes give every pair, then one add too many
   task automatic test_fill_and_full();
      send_mask(4'd1, 16'hFFFF);
      for (int i = 0; i < SLOTS_DEF; i++)
         send_add(16'(i), 16'(i), 15'd100, 15'd100, 4'd1, 1'b1);
      send_add(16'sd0, 16'sd0, 15'd1, 15'd1, 4'd2, 1'b1);
      send_sweep();
   endtask

   task automatic test_remove();
      send_remove(3'd5);
      send_remove(3'd5);
      send_remove(3'd0);
      send_remove(3'd1);
      send_remove(3'd2);
   endtask

   // coordinate extremes, corner contact, and a touching pair nobody is told about
   task automatic test_edge_boxes();
      send_add(-16'sd32768, -16'sd32768, 15'h7FFF, 15'h7FFF, 4'd15, 1'b1);
      send_add(16'sd32767, 16'sd32767, 15'h7FFF, 15'h7FFF, 4'd0, 1'b0);
      send_add(-16'sd1, -16'sd1, 15'd0, 15'd0, 4'd1, 1'b0);
      send_add(16'sd107, 16'sd107, 15'd0, 15'd0, 4'd1, 1'b1);
      send_sweep();
      send_mask(4'd15, 16'h8002);
      send_sweep();
   endtask

   task automatic test_random(int count);
      int                 r;
      logic [1:0]         cmd;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [14:0]        w;
      logic [14:0]        h;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 40) cmd = CMD_ADD;
         else if (r < 60) cmd = CMD_REMOVE;
         else if (r < 82) cmd = CMD_SWEEP;
         else cmd = CMD_MASK;
         // mostly a crowded small area so sweeps find many pairs
         if ($urandom_range(0, 9) < 8) begin
            x = 16'(int'($urandom_range(0, 255)) - 128);
            y = 16'(int'($urandom_range(0, 255)) - 128);
            w = 15'($urandom_range(0, 64));
            h = 15'($urandom_range(0, 64));
         end else begin
            x = 16'($urandom);
            y = 16'($urandom);
            w = 15'($urandom);
            h = 15'($urandom);
         end
         send_command(cmd, 3'($urandom), x, y, w, h, 4'($urandom), 1'($urandom),
                      16'($urandom));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 6;
      rsp_idle_pct = 73;
      test_empty_sweep();
      test_fill_and_full();
      test_remove();
      test_edge_boxes();
      test_random(52);

      send_idle_pct = 73;
      rsp_idle_pct = 6;
      test_random(52);

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random(52);
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      if (fail_count == 0 && pending_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #(8 * 400000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire
